// ===== rtl/core/sfrc_pkg.sv =====
// Shared types and constants for the serial frame receiver and checker.
// Used by the frame assembler, the frame checker and the top level.
package sfrc_pkg;

    localparam int unsigned FrameLen     = 10;
    localparam int unsigned StoredBytes  = 8;
    localparam int unsigned PosWidth     = 4;

    localparam logic [7:0] START_BYTE   = 8'h7E;
    localparam logic [7:0] VERSION_BYTE = 8'hFF;
    localparam logic [7:0] LENGTH_BYTE  = 8'h06;
    localparam logic [7:0] END_BYTE     = 8'hEF;

    localparam logic [PosWidth-1:0] POS_HUNT     = 4'd0;
    localparam logic [PosWidth-1:0] POS_FIRST    = 4'd1;
    localparam logic [PosWidth-1:0] POS_SUM_LAST = 4'd6;
    localparam logic [PosWidth-1:0] POS_STORE_LAST = 4'd8;
    localparam logic [PosWidth-1:0] POS_LAST     = 4'd9;

    localparam int unsigned IdxVersion  = 0;
    localparam int unsigned IdxLength   = 1;
    localparam int unsigned IdxCommand  = 2;
    localparam int unsigned IdxFeedback = 3;
    localparam int unsigned IdxParamHi  = 4;
    localparam int unsigned IdxParamLo  = 5;
    localparam int unsigned IdxCheckHi  = 6;
    localparam int unsigned IdxCheckLo  = 7;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_VERSION  = 3'd1,
        ST_BAD_LENGTH   = 3'd2,
        ST_BAD_END      = 3'd3,
        ST_BAD_CHECKSUM = 3'd4
    } t_status;

    typedef struct packed {
        logic                        last;
        logic [StoredBytes-1:0][7:0] data;
        logic [15:0]                 sum;
    } t_frame;

endpackage

// ===== rtl/core/sfrc_assembler.sv =====
// Frame assembler: start byte hunt, byte position counter, frame bytes and running sum.
// Depends on sfrc_pkg.
module sfrc_assembler (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic [7:0]      i_byte,
    output sfrc_pkg::t_frame o_frame
);
    import sfrc_pkg::*;

    logic [PosWidth-1:0]         r_pos, n_pos;
    logic [15:0]                 r_sum, n_sum;
    logic [StoredBytes-1:0][7:0] r_data, n_data;
    logic [PosWidth-1:0]         w_pm1;
    logic                        w_hunt;

    assign w_pm1  = r_pos - POS_FIRST;
    assign w_hunt = (r_pos == POS_HUNT) || (r_pos > POS_LAST);

    always_comb begin
        n_pos  = r_pos;
        n_sum  = r_sum;
        n_data = r_data;
        if (i_take) begin
            if (w_hunt) begin
                n_pos = POS_HUNT;
                if (i_byte == START_BYTE) begin
                    n_pos = POS_FIRST;
                    n_sum = 16'd0;
                end
            end else begin
                if (r_pos <= POS_STORE_LAST) begin
                    n_data[w_pm1[2:0]] = i_byte;
                end
                if (r_pos <= POS_SUM_LAST) begin
                    n_sum = r_sum + {8'd0, i_byte};
                end
                if (r_pos == POS_LAST) begin
                    n_pos = POS_HUNT;
                end else begin
                    n_pos = r_pos + POS_FIRST;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HUNT;
            r_sum <= 16'd0;
        end else begin
            r_pos <= n_pos;
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_frame.last = (r_pos == POS_LAST);
    assign o_frame.data = r_data;
    assign o_frame.sum  = r_sum;

endmodule

// ===== rtl/core/sfrc_checker.sv =====
// Frame checker: picks the first failing check from the stored bytes and the end byte.
// Depends on sfrc_pkg.
module sfrc_checker (
    input  sfrc_pkg::t_frame  i_frame,
    input  logic [7:0]        i_end_byte,
    output sfrc_pkg::t_status o_status
);
    import sfrc_pkg::*;

    logic [15:0] w_got;
    logic [15:0] w_total;

    assign w_got   = {i_frame.data[IdxCheckHi], i_frame.data[IdxCheckLo]};
    assign w_total = w_got + i_frame.sum;

    always_comb begin
        if (i_frame.data[IdxVersion] != VERSION_BYTE) begin
            o_status = ST_BAD_VERSION;
        end else if (i_frame.data[IdxLength] != LENGTH_BYTE) begin
            o_status = ST_BAD_LENGTH;
        end else if (i_end_byte != END_BYTE) begin
            o_status = ST_BAD_END;
        end else if (w_total != 16'd0) begin
            o_status = ST_BAD_CHECKSUM;
        end else begin
            o_status = ST_OK;
        end
    end

endmodule

// ===== rtl/core/serial_frame_receiver_checker.sv =====
// Top level of the serial frame receiver and checker: assembler, checker and result register.
// Depends on sfrc_pkg, sfrc_assembler and sfrc_checker.
//
//   channel | handshake              | payload
//   rx      | i_rx_valid, o_rx_ready | i_rx_byte
//   res     | o_res_valid, i_res_ready | o_frame_status, o_command_code,
//           |                        |   o_feedback_byte, o_parameter_res
//
// One item is taken per cycle unless stalled; a frame's tenth byte loads the result register.
// A result appears in the cycle after the tenth byte is taken.
// Reset returns the block to hunting for the start byte with no result pending.
// While a result waits, bytes other than a tenth byte are still taken; a tenth byte
// waits only until the pending result is taken, which may happen in the same cycle.
module serial_frame_receiver_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [2:0]  o_frame_status,
    output logic [7:0]  o_command_code,
    output logic [7:0]  o_feedback_byte,
    output logic [15:0] o_parameter_res
);
    import sfrc_pkg::*;

    t_frame      w_frame;
    t_status     w_status;
    logic        w_take;
    logic        w_load;
    logic        r_out_valid, n_out_valid;
    t_status     r_status;
    logic [7:0]  r_command;
    logic [7:0]  r_feedback;
    logic [15:0] r_param;

    assign o_rx_ready = !r_out_valid || i_res_ready || !w_frame.last;
    assign w_take     = i_rx_valid && o_rx_ready;
    assign w_load     = w_take && w_frame.last;

    sfrc_assembler u_assembler (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_byte  (i_rx_byte),
        .o_frame (w_frame)
    );

    sfrc_checker u_checker (
        .i_frame    (w_frame),
        .i_end_byte (i_rx_byte),
        .o_status   (w_status)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_res_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status   <= w_status;
            r_command  <= w_frame.data[IdxCommand];
            r_feedback <= w_frame.data[IdxFeedback];
            r_param    <= {w_frame.data[IdxParamHi], w_frame.data[IdxParamLo]};
        end
    end

    assign o_res_valid     = r_out_valid;
    assign o_frame_status  = r_status;
    assign o_command_code  = r_command;
    assign o_feedback_byte = r_feedback;
    assign o_parameter_res = r_param;

`ifndef SYNTH
    a_load_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_res_valid)
        else $error("tenth byte taken but no result is pending");

    a_stall_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rx_ready |-> (o_res_valid && w_frame.last && !i_res_ready))
        else $error("input stalled without a blocked result");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_frame_status <= 3'd4))
        else $error("result status out of range");
`endif

endmodule
